// File: hdl/scpc_pkg.sv
// shared codes and types for the swept circle point cast block
package scpc_pkg;

  // configuration register indexes
  localparam logic [2:0] CFG_START_X = 3'd0;
  localparam logic [2:0] CFG_START_Z = 3'd1;
  localparam logic [2:0] CFG_DIR_X   = 3'd2;
  localparam logic [2:0] CFG_DIR_Z   = 3'd3;
  localparam logic [2:0] CFG_SWEEP   = 3'd4;
  localparam logic [2:0] CFG_RADIUS  = 3'd5;

  // item modes
  localparam logic [1:0] MODE_PREP  = 2'd0;
  localparam logic [1:0] MODE_CLEAR = 2'd1;
  localparam logic [1:0] MODE_TEST  = 2'd2;
  localparam logic [1:0] MODE_SPARE = 2'd3;

  // root / divide unit operations
  localparam logic OP_ROOT = 1'b0;
  localparam logic OP_DIV  = 1'b1;

  typedef struct packed {
    logic start;
    logic op;
  } unit_req_t;

endpackage

// File: hdl/swept_circle_point_cast.sv
// top level: swept circle versus point cast, sequencer around one multiplier and one root/divide unit
// Takes one item at a time; in_ready is high only while the sequencer is idle. A clear item or an
// unused mode goes straight to the done step. A point item runs through one shared multiplier (one
// product per cycle) and, when it reaches the touch test, one square root. It ends before the
// touch test when the point lies behind the start, beyond the radius or already inside the
// circle; after the root it ends when no nearer touch is found, or for a new contact computes the
// new end point first. A prepare item needs one root and two restoring divides, or only the root
// for a degenerate direction. The result sits in an output register, so the next item may be
// accepted while it waits to be taken.
module swept_circle_point_cast #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  // item channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    mode,
  input  logic signed [COORD_WIDTH-1:0] point_x,
  input  logic signed [COORD_WIDTH-1:0] point_z,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          hit_now,
  output logic                          hit_any,
  output logic [COORD_WIDTH-2:0]        near_dist,
  output logic signed [COORD_WIDTH-1:0] near_end_x,
  output logic signed [COORD_WIDTH-1:0] near_end_z,
  output logic signed [COORD_WIDTH-1:0] touch_x,
  output logic signed [COORD_WIDTH-1:0] touch_z,
  // configuration write channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [2:0]                    cfg_index,
  input  logic [COORD_WIDTH-1:0]        cfg_data
);
  localparam int W   = COORD_WIDTH;
  localparam int F   = FRAC_BITS;
  localparam int SW  = 2 * W + 6;      // wide signed working width
  localparam int MW  = W + 2;          // multiplier operand width
  localparam int PW  = 2 * MW;         // product width
  localparam int RW  = 2 * W;          // root argument width
  localparam int DVW = W + F + 1;      // dividend / quotient width
  localparam int AW  = 2 * W + F + 1;  // unit argument port width

  localparam logic signed [SW-1:0] CMAX_S = $signed({{(SW-W+1){1'b0}}, {(W-1){1'b1}}});
  localparam logic signed [SW-1:0] CMIN_S = $signed({{(SW-W+1){1'b1}}, {(W-1){1'b0}}});
  localparam logic signed [SW-1:0] ONE_S  = $signed(SW'(1) << F);
  localparam logic signed [W-1:0]  ONE_W  = $signed(ONE_S[W-1:0]);

  // sequencer codes
  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_P0   = 5'd1;
  localparam logic [4:0] S_P1   = 5'd2;
  localparam logic [4:0] S_P2   = 5'd3;
  localparam logic [4:0] S_P3   = 5'd4;
  localparam logic [4:0] S_P4   = 5'd5;
  localparam logic [4:0] S_P5   = 5'd6;
  localparam logic [4:0] S_P6   = 5'd7;
  localparam logic [4:0] S_P7   = 5'd8;
  localparam logic [4:0] S_P8   = 5'd9;
  localparam logic [4:0] S_P9   = 5'd10;
  localparam logic [4:0] S_T0   = 5'd11;
  localparam logic [4:0] S_T1   = 5'd12;
  localparam logic [4:0] S_T2   = 5'd13;
  localparam logic [4:0] S_T3   = 5'd14;
  localparam logic [4:0] S_T4   = 5'd15;
  localparam logic [4:0] S_T5   = 5'd16;
  localparam logic [4:0] S_T6   = 5'd17;
  localparam logic [4:0] S_T7   = 5'd18;
  localparam logic [4:0] S_T8   = 5'd19;
  localparam logic [4:0] S_T9   = 5'd20;
  localparam logic [4:0] S_T10  = 5'd21;
  localparam logic [4:0] S_T11  = 5'd22;
  localparam logic [4:0] S_T12  = 5'd23;
  localparam logic [4:0] S_DONE = 5'd24;

  // round to nearest, ties away from zero, dropping the fraction bits
  function automatic logic signed [SW-1:0] sdown(input logic signed [SW-1:0] a);
    logic [SW-1:0] m;
    logic [SW-1:0] r;
    m = a[SW-1] ? -a : a;
    r = (m + (SW'(1) << (F - 1))) >> F;
    sdown = a[SW-1] ? -$signed(r) : $signed(r);
  endfunction

  function automatic logic signed [W-1:0] satc(input logic signed [SW-1:0] a);
    if (a > CMAX_S)      satc = $signed(CMAX_S[W-1:0]);
    else if (a < CMIN_S) satc = $signed(CMIN_S[W-1:0]);
    else                 satc = $signed(a[W-1:0]);
  endfunction

  function automatic logic [W-2:0] satd(input logic signed [SW-1:0] a);
    if (a < 0)           satd = '0;
    else if (a > CMAX_S) satd = '1;
    else                 satd = a[W-2:0];
  endfunction

  // configuration registers
  logic signed [W-1:0] start_x, start_z, dir_x, dir_z;
  logic [W-2:0]        sweep_dist, radius;

  // cast state
  logic signed [W-1:0] unit_dir_x, unit_dir_z, full_end_x, full_end_z;
  logic signed [W-1:0] run_end_x, run_end_z, contact_x, contact_z;
  logic [W-2:0]        full_dist, run_dist;
  logic                hit_flag;

  // working registers
  logic [4:0]           state;
  logic signed [W-1:0]  px, pz, tx, tz;
  logic signed [PW-1:0] prod;
  logic signed [SW-1:0] acc, along, away, r2;
  logic [W-1:0]         len;
  logic                 hit_r;

  // shared multiplier
  logic signed [MW-1:0] mul_a, mul_b;
  logic signed [PW-1:0] mul_res;

  // root / divide unit
  scpc_pkg::unit_req_t  u_req;
  logic [AW-1:0]        u_arg_a;
  logic [W-1:0]         u_arg_b;
  logic                 u_done;
  logic [DVW-1:0]       u_result;

  // combinational helpers
  logic signed [SW-1:0] prod_s, sum_s, along_c, away_c, rad_s, sq_s;
  logic [W-1:0]         mag_dx, mag_dz;
  logic signed [W-1:0]  q_w;

  assign prod_s  = SW'(prod);
  assign sum_s   = acc + prod_s;
  assign along_c = -sdown(sum_s);
  assign away_c  = sdown(sum_s);
  assign rad_s   = $signed(SW'(radius));
  assign sq_s    = $signed(SW'(u_result[W-1:0]));
  assign mag_dx  = dir_x[W-1] ? W'(-dir_x) : W'(dir_x);
  assign mag_dz  = dir_z[W-1] ? W'(-dir_z) : W'(dir_z);
  assign q_w     = $signed(u_result[W-1:0]);
  assign mul_res = PW'(mul_a) * PW'(mul_b);

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  // multiplier operand selection per step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_P0:  begin mul_a = MW'(dir_x);      mul_b = $signed(MW'(sweep_dist)); end
      S_P1:  begin mul_a = MW'(dir_z);      mul_b = $signed(MW'(sweep_dist)); end
      S_P2:  begin mul_a = MW'(dir_x);      mul_b = MW'(dir_x); end
      S_P3:  begin mul_a = MW'(dir_z);      mul_b = MW'(dir_z); end
      S_P8:  begin mul_a = $signed(MW'(sweep_dist)); mul_b = $signed(MW'(len)); end
      S_T0:  begin mul_a = MW'(unit_dir_x); mul_b = MW'(tx); end
      S_T1:  begin mul_a = MW'(unit_dir_z); mul_b = MW'(tz); end
      S_T2:  begin mul_a = -MW'(unit_dir_z); mul_b = MW'(tx); end
      S_T3:  begin mul_a = MW'(unit_dir_x); mul_b = MW'(tz); end
      S_T4:  begin mul_a = $signed(MW'(radius)); mul_b = $signed(MW'(radius)); end
      S_T5:  begin mul_a = MW'(tx);         mul_b = MW'(tx); end
      S_T6:  begin mul_a = MW'(tz);         mul_b = MW'(tz); end
      S_T7:  begin mul_a = $signed(away[MW-1:0]); mul_b = $signed(away[MW-1:0]); end
      S_T10: begin mul_a = MW'(unit_dir_x); mul_b = $signed(MW'(run_dist)); end
      S_T11: begin mul_a = MW'(unit_dir_z); mul_b = $signed(MW'(run_dist)); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  // unit requests: length root, two unit-vector divides, touch root
  always_comb begin
    u_req   = '{start: 1'b0, op: scpc_pkg::OP_ROOT};
    u_arg_a = '0;
    u_arg_b = '0;
    unique case (state)
      S_P4: begin
        u_req   = '{start: 1'b1, op: scpc_pkg::OP_ROOT};
        u_arg_a = AW'(sum_s[RW-1:0]);
      end
      S_P5: begin
        if (u_done && (u_result != '0)) begin
          u_req   = '{start: 1'b1, op: scpc_pkg::OP_DIV};
          u_arg_a = AW'((DVW'(mag_dx) << F) + DVW'(u_result[W-1:0] >> 1));
          u_arg_b = u_result[W-1:0];
        end
      end
      S_P6: begin
        if (u_done) begin
          u_req   = '{start: 1'b1, op: scpc_pkg::OP_DIV};
          u_arg_a = AW'((DVW'(mag_dz) << F) + DVW'(len >> 1));
          u_arg_b = len;
        end
      end
      S_T8: begin
        u_req   = '{start: 1'b1, op: scpc_pkg::OP_ROOT};
        u_arg_a = AW'((r2 - prod_s + ONE_S) >>> 0);
      end
      default: ;
    endcase
  end

  scpc_root_div #(
    .COORD_WIDTH(COORD_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_root_div (
    .clk   (clk),
    .rst   (rst),
    .req   (u_req),
    .arg_a (u_arg_a),
    .arg_b (u_arg_b),
    .done  (u_done),
    .result(u_result)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      start_x    <= '0;
      start_z    <= '0;
      dir_x      <= '0;
      dir_z      <= '0;
      sweep_dist <= '0;
      radius     <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        scpc_pkg::CFG_START_X: start_x    <= cfg_data;
        scpc_pkg::CFG_START_Z: start_z    <= cfg_data;
        scpc_pkg::CFG_DIR_X:   dir_x      <= cfg_data;
        scpc_pkg::CFG_DIR_Z:   dir_z      <= cfg_data;
        scpc_pkg::CFG_SWEEP:   sweep_dist <= cfg_data[W-2:0];
        scpc_pkg::CFG_RADIUS:  radius     <= cfg_data[W-2:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      unit_dir_x <= '0;
      unit_dir_z <= '0;
      full_dist  <= '0;
      full_end_x <= '0;
      full_end_z <= '0;
      run_dist   <= '0;
      run_end_x  <= '0;
      run_end_z  <= '0;
      hit_flag   <= 1'b0;
      contact_x  <= '0;
      contact_z  <= '0;
      hit_r      <= 1'b0;
    end else begin
      prod <= mul_res;
      // a finishing transaction reloads the output in S_DONE instead
      if (out_valid && out_ready && state != S_DONE) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            hit_r <= 1'b0;
            px    <= point_x;
            pz    <= point_z;
            tx    <= satc(SW'(start_x) - SW'(point_x));
            tz    <= satc(SW'(start_z) - SW'(point_z));
            unique case (mode)
              scpc_pkg::MODE_PREP: state <= S_P0;
              scpc_pkg::MODE_TEST: state <= S_T0;
              scpc_pkg::MODE_CLEAR: begin
                run_dist  <= full_dist;
                run_end_x <= full_end_x;
                run_end_z <= full_end_z;
                hit_flag  <= 1'b0;
                state     <= S_DONE;
              end
              default: state <= S_DONE;  // unused mode reports the state as is
            endcase
          end
        end
        // prepare: end point, direction length, unit vector, scaled distance
        S_P0: state <= S_P1;
        S_P1: begin
          full_end_x <= satc(SW'(start_x) + sdown(prod_s));
          state      <= S_P2;
        end
        S_P2: begin
          full_end_z <= satc(SW'(start_z) + sdown(prod_s));
          state      <= S_P3;
        end
        S_P3: begin
          acc   <= prod_s;
          state <= S_P4;
        end
        S_P4: state <= S_P5;
        S_P5: begin
          if (u_done) begin
            len <= u_result[W-1:0];
            if (u_result == '0) begin
              // degenerate direction: +Z, no distance
              unit_dir_x <= '0;
              unit_dir_z <= ONE_W;
              full_dist  <= '0;
              run_dist   <= '0;
              run_end_x  <= full_end_x;
              run_end_z  <= full_end_z;
              hit_flag   <= 1'b0;
              state      <= S_DONE;
            end else begin
              state <= S_P6;
            end
          end
        end
        S_P6: begin
          if (u_done) begin
            unit_dir_x <= dir_x[W-1] ? -q_w : q_w;
            state      <= S_P7;
          end
        end
        S_P7: begin
          if (u_done) begin
            unit_dir_z <= dir_z[W-1] ? -q_w : q_w;
            state      <= S_P8;
          end
        end
        S_P8: state <= S_P9;
        S_P9: begin
          full_dist <= satd(sdown(prod_s));
          run_dist  <= satd(sdown(prod_s));
          run_end_x <= full_end_x;
          run_end_z <= full_end_z;
          hit_flag  <= 1'b0;
          state     <= S_DONE;
        end
        // point test
        S_T0: state <= S_T1;
        S_T1: begin
          acc   <= prod_s;
          state <= S_T2;
        end
        S_T2: begin
          along <= along_c;
          state <= (along_c <= 0) ? S_DONE : S_T3;  // behind the start
        end
        S_T3: begin
          acc   <= prod_s;
          state <= S_T4;
        end
        S_T4: begin
          away <= away_c;
          // sideways beyond the radius
          if (away_c >= rad_s || away_c <= -rad_s) state <= S_DONE;
          else                                     state <= S_T5;
        end
        S_T5: begin
          r2    <= prod_s;
          state <= S_T6;
        end
        S_T6: begin
          acc   <= prod_s;
          state <= S_T7;
        end
        S_T7: begin
          if (sum_s <= r2) begin
            // point already inside the circle at the start
            hit_r     <= 1'b1;
            hit_flag  <= 1'b1;
            run_dist  <= '0;
            run_end_x <= start_x;
            run_end_z <= start_z;
            contact_x <= px;
            contact_z <= pz;
            state     <= S_DONE;
          end else begin
            state <= S_T8;
          end
        end
        S_T8: state <= S_T9;
        S_T9: begin
          if (u_done) begin
            if (along < $signed(SW'(run_dist)) + sq_s) begin
              run_dist  <= satd(along - sq_s);
              hit_r     <= 1'b1;
              hit_flag  <= 1'b1;
              contact_x <= px;
              contact_z <= pz;
              state     <= S_T10;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_T10: state <= S_T11;
        S_T11: begin
          run_end_x <= satc(SW'(start_x) + sdown(prod_s));
          state     <= S_T12;
        end
        S_T12: begin
          run_end_z <= satc(SW'(start_z) + sdown(prod_s));
          state     <= S_DONE;
        end
        S_DONE: begin
          // hold until the output register is free
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // result register, loaded when the transaction finishes
  always_ff @(posedge clk) begin
    if (state == S_DONE && (!out_valid || out_ready)) begin
      hit_now    <= hit_r;
      hit_any    <= hit_flag;
      near_dist  <= run_dist;
      near_end_x <= run_end_x;
      near_end_z <= run_end_z;
      touch_x    <= contact_x;
      touch_z    <= contact_z;
    end
  end

  // unit only finishes while the sequencer waits for it
  a_unit_done: assert property (@(posedge clk) disable iff (rst)
    u_done |-> (state == S_P5 || state == S_P6 || state == S_P7 || state == S_T9))
    else $error("root/divide unit finished with no step waiting");

  // an accepted transaction keeps the block busy in the following cycle
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("item accepted while the previous one still runs");

  // a reported new contact is always counted as a hit
  a_hit: assert property (@(posedge clk) disable iff (rst)
    out_valid && hit_now |-> hit_any)
    else $error("hit_now without hit_any");

  // the running distance never exceeds the full sweep
  a_dist: assert property (@(posedge clk) disable iff (rst)
    run_dist <= full_dist)
    else $error("running distance beyond full sweep");

endmodule

// File: hdl/scpc_root_div.sv
// iterative unit: floor square root (one result bit a cycle) or restoring divide
module scpc_root_div #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  scpc_pkg::unit_req_t                    req,
  input  logic [2*COORD_WIDTH+FRAC_BITS:0]       arg_a,
  input  logic [COORD_WIDTH-1:0]                 arg_b,
  output logic                                   done,
  output logic [COORD_WIDTH+FRAC_BITS:0]         result
);
  localparam int W   = COORD_WIDTH;
  localparam int F   = FRAC_BITS;
  localparam int RW  = 2 * W;
  localparam int DVW = W + F + 1;
  localparam int CW  = $clog2(DVW + 1);

  logic          active;
  logic          op_r;
  logic [CW-1:0] cnt;
  logic [RW-1:0] v, res, bitr;
  logic [W-1:0]  rem, dvs;
  logic [DVW-1:0] dvd, quo;

  logic [RW-1:0] trial;
  logic [W:0]    rem_sh, diff;
  logic          fits;

  assign trial  = res + bitr;
  assign rem_sh = {rem, dvd[DVW-1]};
  assign fits   = rem_sh >= {1'b0, dvs};
  assign diff   = rem_sh - {1'b0, dvs};

  assign result = (op_r == scpc_pkg::OP_ROOT) ? DVW'(res[W-1:0]) : quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        active <= 1'b1;
        op_r   <= req.op;
        if (req.op == scpc_pkg::OP_ROOT) begin
          v    <= arg_a[RW-1:0];
          res  <= '0;
          bitr <= RW'(1) << (RW - 2);
          cnt  <= CW'(W);
        end else begin
          rem <= '0;
          dvd <= arg_a[DVW-1:0];
          quo <= '0;
          dvs <= arg_b;
          cnt <= CW'(DVW);
        end
      end else if (active) begin
        if (op_r == scpc_pkg::OP_ROOT) begin
          if (v >= trial) begin
            v   <= v - trial;
            res <= (res >> 1) + bitr;
          end else begin
            res <= res >> 1;
          end
          bitr <= bitr >> 2;
        end else begin
          rem <= fits ? diff[W-1:0] : rem_sh[W-1:0];
          quo <= {quo[DVW-2:0], fits};
          dvd <= dvd << 1;
        end
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

endmodule

// File: test/swept_circle_point_cast_tb.sv
// testbench for the swept circle point cast block: directed table plus random casts, predicted
module swept_circle_point_cast_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW = 32;
  localparam int FB = 16;
  localparam longint CMAX = (64'sd1 <<< (CW - 1)) - 1;
  localparam longint CMIN = -(64'sd1 <<< (CW - 1));
  localparam longint DMAX = (64'sd1 <<< (CW - 1)) - 1;
  localparam longint ONE_Q = 64'sd1 <<< FB;
  localparam longint LIMIT = 3000000;

  typedef struct packed {
    logic        hit_now;
    logic        hit_any;
    logic [30:0] near_dist;
    logic [31:0] near_end_x;
    logic [31:0] near_end_z;
    logic [31:0] touch_x;
    logic [31:0] touch_z;
  } cast_result_t;

  typedef struct {
    logic [1:0]  mode;
    logic [31:0] px;
    logic [31:0] pz;
    logic        known;   // result typed in below
    cast_result_t res;
  } stim_row_t;

  logic clk = 1'b0, rst = 1'b1;
  logic in_valid = 1'b0, out_ready = 1'b0, cfg_valid = 1'b0;
  logic [1:0] mode = scpc_pkg::MODE_CLEAR;
  logic signed [31:0] point_x = '0, point_z = '0;
  logic [2:0] cfg_index = scpc_pkg::CFG_START_X;
  logic [31:0] cfg_data = '0;
  logic in_ready, out_valid, cfg_ready, hit_now, hit_any;
  logic [30:0] near_dist;
  logic signed [31:0] near_end_x, near_end_z, touch_x, touch_z;

  swept_circle_point_cast u_dut (.*);

  // predictor copy of registers and state
  longint r_sx, r_sz, r_dx, r_dz, r_sweep, r_rad;
  longint ux, uz, f_dist, f_ex, f_ez, n_dist, n_ex, n_ez, c_x, c_z;
  bit hflag;

  cast_result_t pending_casts[$];
  int errors = 0;
  longint cycle = 0;
  bit hold_long = 1'b0;
  bit stim_done = 1'b0;

  initial forever #5 clk = ~clk;

  // cycle counter and timeout
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic longint sat_coord(longint v);
    return v > CMAX ? CMAX : (v < CMIN ? CMIN : v);
  endfunction

  function automatic longint sat_dist(longint v);
    return v < 0 ? 0 : (v > DMAX ? DMAX : v);
  endfunction

  function automatic longint abs64(longint a);
    return a < 0 ? -a : a;
  endfunction

  // round to nearest, ties away from zero, dropping the fraction bits
  function automatic longint round_q(longint a);
    longint unsigned m;
    m = (longint'(abs64(a)) + (64'd1 << (FB - 1))) >> FB;
    return a < 0 ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint unsigned int_root(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else res >>= 1;
      b >>= 2;
    end
    return res;
  endfunction

  function automatic longint unit_part(longint c, longint unsigned len);
    longint unsigned q;
    q = ((longint'(abs64(c)) << FB) + (len >> 1)) / len;
    return c < 0 ? -longint'(q) : longint'(q);
  endfunction

  function automatic void restart_run();
    n_dist = f_dist; n_ex = f_ex; n_ez = f_ez; hflag = 0;
  endfunction

  function automatic void prep_sweep();
    longint unsigned len, ax, az;
    f_ex = sat_coord(r_sx + round_q(r_dx * r_sweep));
    f_ez = sat_coord(r_sz + round_q(r_dz * r_sweep));
    ax = abs64(r_dx); az = abs64(r_dz);
    len = int_root(ax * ax + az * az);
    if (len < 1) begin
      ux = 0; uz = ONE_Q; f_dist = 0;
    end else begin
      ux = unit_part(r_dx, len);
      uz = unit_part(r_dz, len);
      f_dist = sat_dist(longint'((longint'(r_sweep) * len + (64'd1 << (FB - 1))) >> FB));
    end
    restart_run();
  endfunction

  function automatic bit cast_point(longint px, longint pz);
    longint tx, tz, along, away, back, nd;
    longint unsigned r2, q, mx, mz, ma;
    tx = sat_coord(r_sx - px); tz = sat_coord(r_sz - pz);
    along = -round_q(ux * tx + uz * tz);
    if (along <= 0) return 0;
    away = round_q(-uz * tx + ux * tz);
    if (away <= -r_rad || away >= r_rad) return 0;
    r2 = r_rad * r_rad;
    mx = abs64(tx); mz = abs64(tz);
    if (mx * mx + mz * mz <= r2) begin
      hflag = 1; n_dist = 0; n_ex = r_sx; n_ez = r_sz; c_x = px; c_z = pz;
      return 1;
    end
    ma = abs64(away);
    q = r2 - ma * ma + (64'd1 << FB);
    back = r_rad - longint'(int_root(q));
    if (along < n_dist + r_rad - back) begin
      nd = along + back - r_rad;
      n_dist = sat_dist(nd);
      n_ex = sat_coord(r_sx + round_q(ux * n_dist));
      n_ez = sat_coord(r_sz + round_q(uz * n_dist));
      hflag = 1; c_x = px; c_z = pz;
      return 1;
    end
    return 0;
  endfunction

  function automatic cast_result_t predict_cast(logic [1:0] m, logic [31:0] px, logic [31:0] pz);
    cast_result_t r;
    bit now;
    now = 0;
    if (m == scpc_pkg::MODE_PREP) prep_sweep();
    else if (m == scpc_pkg::MODE_CLEAR) restart_run();
    else if (m == scpc_pkg::MODE_TEST)
      now = cast_point(longint'($signed(px)), longint'($signed(pz)));
    r.hit_now = now; r.hit_any = hflag;
    r.near_dist = n_dist[30:0];
    r.near_end_x = n_ex[31:0]; r.near_end_z = n_ez[31:0];
    r.touch_x = c_x[31:0]; r.touch_z = c_z[31:0];
    return r;
  endfunction

  function automatic int short_gap();
    // mostly none or short, now and then long
    int k;
    k = $urandom_range(0, 99);
    if (k < 45) return 0;
    if (k < 95) return $urandom_range(1, 4);
    return $urandom_range(20, 120);
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      scpc_pkg::CFG_START_X: r_sx = longint'($signed(val));
      scpc_pkg::CFG_START_Z: r_sz = longint'($signed(val));
      scpc_pkg::CFG_DIR_X:   r_dx = longint'($signed(val));
      scpc_pkg::CFG_DIR_Z:   r_dz = longint'($signed(val));
      scpc_pkg::CFG_SWEEP:   r_sweep = longint'(val[30:0]);
      default:               r_rad = longint'(val[30:0]);
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // wait until every transaction has returned, then let the block settle
  task automatic drain();
    while (pending_casts.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  // one input transaction; predicted result queued at acceptance
  task automatic send_item(logic [1:0] m, logic [31:0] px, logic [31:0] pz, bit gaps);
    int g;
    g = gaps ? short_gap() : 0;
    @(negedge clk);
    repeat (g) @(negedge clk);
    in_valid <= 1'b1; mode <= m; point_x <= px; point_z <= pz;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_casts.push_back(predict_cast(m, px, pz));
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic set_sweep(logic [31:0] sx, logic [31:0] sz, logic [31:0] dx,
                           logic [31:0] dz, logic [31:0] sw, logic [31:0] rad);
    drain();
    write_reg(scpc_pkg::CFG_START_X, sx); write_reg(scpc_pkg::CFG_START_Z, sz);
    write_reg(scpc_pkg::CFG_DIR_X, dx);   write_reg(scpc_pkg::CFG_DIR_Z, dz);
    write_reg(scpc_pkg::CFG_SWEEP, sw);   write_reg(scpc_pkg::CFG_RADIUS, rad);
    send_item(scpc_pkg::MODE_PREP, '0, '0, 0);
  endtask

  function automatic logic [31:0] rnd_coord();
    int k;
    k = $urandom_range(0, 9);
    if (k == 0) return $urandom();
    if (k == 1) return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
    return $signed($urandom_range(0, 32'h00a0_0000)) - 32'sh0050_0000;
  endfunction

  // receiver: random stalls, one long hold-off when asked
  initial begin
    int g;
    @(negedge clk);
    while (1) begin
      if (hold_long) begin
        out_ready <= 1'b0;
        repeat (600) @(negedge clk);
        hold_long = 0;
      end
      g = short_gap();
      if (g != 0) begin
        out_ready <= 1'b0;
        repeat (g) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(negedge clk);
    end
  end

  // checker at the rising edge
  always @(posedge clk) begin
    cast_result_t exp_r;
    if (!rst && out_valid && out_ready) begin
      if (pending_casts.size() == 0) begin
        $error("unexpected result transaction");
        errors++;
      end else begin
        exp_r = pending_casts.pop_front();
        if (hit_now !== exp_r.hit_now) begin
          $error("hit_now exp %0d got %0d", exp_r.hit_now, hit_now); errors++;
        end
        if (hit_any !== exp_r.hit_any) begin
          $error("hit_any exp %0d got %0d", exp_r.hit_any, hit_any); errors++;
        end
        if (near_dist !== exp_r.near_dist) begin
          $error("near_dist exp %h got %h", exp_r.near_dist, near_dist); errors++;
        end
        if (near_end_x !== exp_r.near_end_x) begin
          $error("near_end_x exp %h got %h", exp_r.near_end_x, near_end_x); errors++;
        end
        if (near_end_z !== exp_r.near_end_z) begin
          $error("near_end_z exp %h got %h", exp_r.near_end_z, near_end_z); errors++;
        end
        if (touch_x !== exp_r.touch_x) begin
          $error("touch_x exp %h got %h", exp_r.touch_x, touch_x); errors++;
        end
        if (touch_z !== exp_r.touch_z) begin
          $error("touch_z exp %h got %h", exp_r.touch_z, touch_z); errors++;
        end
      end
    end
  end

  // directed table, typed results only where obvious
  stim_row_t dir_rows[$];

  task automatic add_row(logic [1:0] m, logic [31:0] px, logic [31:0] pz,
                         bit known, cast_result_t r);
    stim_row_t s;
    s.mode = m; s.px = px; s.pz = pz; s.known = known; s.res = r;
    dir_rows.push_back(s);
  endtask

  task automatic run_rows();
    foreach (dir_rows[i]) begin
      send_item(dir_rows[i].mode, dir_rows[i].px, dir_rows[i].pz, 1);
      // a typed-in result overrides the prediction, both must agree anyway
      if (dir_rows[i].known) pending_casts[pending_casts.size() - 1] = dir_rows[i].res;
    end
    dir_rows.delete();
  endtask

  initial begin
    cast_result_t zero_r;
    int n;
    r_sx = 0; r_sz = 0; r_dx = 0; r_dz = 0; r_sweep = 0; r_rad = 0;
    ux = 0; uz = 0; f_dist = 0; f_ex = 0; f_ez = 0;
    n_dist = 0; n_ex = 0; n_ez = 0; c_x = 0; c_z = 0; hflag = 0;
    zero_r = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // after reset: everything zero; unused mode reports like a clear
    add_row(scpc_pkg::MODE_CLEAR, '0, '0, 1, zero_r);
    add_row(scpc_pkg::MODE_SPARE, 32'hffffffff, 32'hffffffff, 1, zero_r);
    add_row(scpc_pkg::MODE_PREP, '0, '0, 1, zero_r);      // degenerate direction
    add_row(scpc_pkg::MODE_TEST, '0, 32'h0001_0000, 0, zero_r);
    run_rows();

    // unit sweep along +Z, radius 1.0
    set_sweep(0, 0, 0, 32'h0001_0000, 32'h000a_0000, 32'h0001_0000);
    add_row(scpc_pkg::MODE_TEST, 32'h0000_8000, 32'h0000_4000, 0, zero_r);   // inside circle
    add_row(scpc_pkg::MODE_CLEAR, '0, '0, 0, zero_r);
    add_row(scpc_pkg::MODE_TEST, '0, 32'hfffe_0000, 0, zero_r);              // behind start
    add_row(scpc_pkg::MODE_TEST, 32'h0002_0000, 32'h0003_0000, 0, zero_r);   // too far sideways
    add_row(scpc_pkg::MODE_TEST, '0, 32'h0005_0000, 0, zero_r);              // ahead, touch
    add_row(scpc_pkg::MODE_TEST, 32'h0000_8000, 32'h0003_0000, 0, zero_r);   // nearer
    add_row(scpc_pkg::MODE_TEST, '0, 32'h0008_0000, 0, zero_r);              // farther
    add_row(scpc_pkg::MODE_TEST, '0, 32'h0001_0001, 0, zero_r);              // clamp near zero
    add_row(scpc_pkg::MODE_TEST, 32'h7fffffff, 32'h7fffffff, 0, zero_r);
    add_row(scpc_pkg::MODE_TEST, 32'h80000000, 32'h80000000, 0, zero_r);
    run_rows();

    // extremes of every register
    set_sweep(32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff,
              32'h7fffffff, 32'h7fffffff);
    add_row(scpc_pkg::MODE_TEST, 32'h80000000, 32'h7fffffff, 0, zero_r);
    add_row(scpc_pkg::MODE_TEST, 32'h7fffffff, 32'h80000000, 0, zero_r);
    add_row(scpc_pkg::MODE_TEST, '0, '0, 0, zero_r);
    run_rows();
    set_sweep(32'h80000000, 32'h7fffffff, 32'h0000_0001, 32'hffff_ffff, 0, 0);
    add_row(scpc_pkg::MODE_TEST, 32'h80000001, 32'h7ffffffe, 0, zero_r);
    run_rows();

    // long receiver hold-off while items keep coming
    set_sweep(0, 0, 32'h0003_0000, 32'h0004_0000, 32'h0002_0000, 32'h0002_0000);
    hold_long = 1;
    repeat (12) send_item(scpc_pkg::MODE_TEST, rnd_coord(), rnd_coord(), 0);

    // random phases: moderate sweeps mostly, wild ones sometimes
    n = 0;
    while (n < 850) begin
      if ($urandom_range(0, 4) == 0)
        set_sweep($urandom(), $urandom(), $urandom(), $urandom(),
                  $urandom() & 32'h7fffffff, $urandom() & 32'h7fffffff);
      else
        set_sweep(rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(),
                  $urandom_range(0, 32'h0040_0000), $urandom_range(0, 32'h0040_0000));
      n++;
      repeat ($urandom_range(10, 50)) begin
        case ($urandom_range(0, 19))
          0: send_item(scpc_pkg::MODE_CLEAR, $urandom(), $urandom(), 1);
          1: send_item(scpc_pkg::MODE_SPARE, $urandom(), $urandom(), 1);
          2: send_item(scpc_pkg::MODE_PREP, $urandom(), $urandom(), 1);
          3: send_item(scpc_pkg::MODE_TEST, $urandom(), $urandom(), 1);
          default: send_item(scpc_pkg::MODE_TEST, rnd_coord(), rnd_coord(), 1);
        endcase
        n++;
      end
    end
    stim_done = 1;
    drain();
    if (errors == 0 && pending_casts.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
